FILE: rtl/ring_fifo_with_match_delete_assert.svh
`ifndef RING_FIFO_WITH_MATCH_DELETE_ASSERT_SVH
`define RING_FIFO_WITH_MATCH_DELETE_ASSERT_SVH

// same-cycle implication
`define RFMD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfmd assertion failed");

// next-cycle implication
`define RFMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfmd assertion failed");

`endif

FILE: rtl/rfmd_pkg.sv
package rfmd_pkg;

   localparam int DEPTH_DEF   = 16;
   localparam int ID_BITS_DEF = 8;
   localparam int STEP_W      = 4;

   typedef enum logic [1:0] {
      FN_PUT = 2'd0,
      FN_POP = 2'd1,
      FN_DEL = 2'd2,
      FN_NOP = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   typedef enum logic [STEP_W-1:0] {
      S_IDLE    = 4'd0,
      S_PUT     = 4'd1,
      S_POPRD   = 4'd2,
      S_POPCHK  = 4'd3,
      S_DELINIT = 4'd4,
      S_DELRD   = 4'd5,
      S_DELCHK  = 4'd6,
      S_DELEND  = 4'd7,
      S_HDRD    = 4'd8,
      S_HDOUT   = 4'd9
   } step_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LATCH,
      ACT_PUT,
      ACT_POPCHK,
      ACT_DELINIT,
      ACT_DELCHK,
      ACT_DELEND,
      ACT_EMIT
   } act_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_HEAD,
      RD_WALK
   } rd_type;

   typedef enum logic [1:0] {
      J_NEXT,
      J_GOTO,
      J_DISPATCH,
      J_WALK_DONE
   } jmp_type;

   typedef struct packed {
      act_type  act;
      rd_type   rd;
      jmp_type  jmp;
      step_type target;
   } ctl_type;

   typedef struct packed {
      logic     accept;
      func_type func;
      logic     walk_done;
   } cond_type;

   function automatic ctl_type ucode(input step_type s);
      ctl_type w;
      w = '{act: ACT_NONE, rd: RD_NONE, jmp: J_GOTO, target: S_IDLE};
      unique case (s)
         S_IDLE:    w = '{act: ACT_LATCH,   rd: RD_NONE, jmp: J_DISPATCH,  target: S_IDLE};
         S_PUT:     w = '{act: ACT_PUT,     rd: RD_NONE, jmp: J_GOTO,      target: S_HDRD};
         S_POPRD:   w = '{act: ACT_NONE,    rd: RD_HEAD, jmp: J_NEXT,      target: S_IDLE};
         S_POPCHK:  w = '{act: ACT_POPCHK,  rd: RD_NONE, jmp: J_GOTO,      target: S_HDRD};
         S_DELINIT: w = '{act: ACT_DELINIT, rd: RD_NONE, jmp: J_NEXT,      target: S_IDLE};
         S_DELRD:   w = '{act: ACT_NONE,    rd: RD_WALK, jmp: J_WALK_DONE, target: S_DELEND};
         S_DELCHK:  w = '{act: ACT_DELCHK,  rd: RD_NONE, jmp: J_GOTO,      target: S_DELRD};
         S_DELEND:  w = '{act: ACT_DELEND,  rd: RD_NONE, jmp: J_NEXT,      target: S_IDLE};
         S_HDRD:    w = '{act: ACT_NONE,    rd: RD_HEAD, jmp: J_NEXT,      target: S_IDLE};
         S_HDOUT:   w = '{act: ACT_EMIT,    rd: RD_NONE, jmp: J_GOTO,      target: S_IDLE};
         default:   w = '{act: ACT_NONE,    rd: RD_NONE, jmp: J_GOTO,      target: S_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/rfmd_ram.sv
module rfmd_ram
   import rfmd_pkg::*;
#(
   parameter int WIDTH = ID_BITS_DEF,
   parameter int DEPTH = DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rfmd_useq.sv
module rfmd_useq
   import rfmd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cond_type cond,
   output ctl_type  ctl,
   output logic     busy
);

   step_type upc_ff, upc_in;
   step_type upc_next;
   step_type dispatch;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      ctl      = ucode(upc_ff);
      upc_next = step_type'(upc_ff + 1'b1);
      unique case (cond.func)
         FN_PUT:  dispatch = S_PUT;
         FN_POP:  dispatch = S_POPRD;
         FN_DEL:  dispatch = S_DELINIT;
         FN_NOP:  dispatch = S_HDRD;
         default: dispatch = S_HDRD;
      endcase
      unique case (ctl.jmp)
         J_NEXT:      upc_in = upc_next;
         J_GOTO:      upc_in = ctl.target;
         J_DISPATCH:  upc_in = cond.accept ? dispatch : upc_ff;
         J_WALK_DONE: upc_in = cond.walk_done ? ctl.target : upc_next;
         default:     upc_in = S_IDLE;
      endcase
   end

   assign busy = (upc_ff != S_IDLE);

endmodule

FILE: rtl/rfmd_dp.sv
module rfmd_dp
   import rfmd_pkg::*;
#(
   parameter int DEPTH   = DEPTH_DEF,
   parameter int ID_BITS = ID_BITS_DEF,
   localparam int PTR_W  = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  logic               accept,
   input  logic [ID_BITS-1:0] req_ident,
   output logic               walk_done,
   output logic               ram_wr_en,
   output logic [PTR_W-1:0]   ram_wr_addr,
   output logic [ID_BITS-1:0] ram_wr_data,
   output logic               ram_rd_en,
   output logic [PTR_W-1:0]   ram_rd_addr,
   input  logic [ID_BITS-1:0] ram_rd_data,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [CNT_W-1:0]   rsp_occupancy,
   output logic [CNT_W-1:0]   rsp_removed_count,
   output logic               rsp_head_valid,
   output logic [ID_BITS-1:0] rsp_head_ident
);

   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ID_BITS-1:0] ident_ff, ident_in;
   status_type         status_ff, status_in;
   logic [CNT_W-1:0]   removed_ff, removed_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   kept_ff, kept_in;
   logic [PTR_W-1:0]   rdp_ff, rdp_in;
   logic [PTR_W-1:0]   wrp_ff, wrp_in;

   function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ident_ff   <= ident_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      idx_ff     <= idx_in;
      kept_ff    <= kept_in;
      rdp_ff     <= rdp_in;
      wrp_ff     <= wrp_in;
   end

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      ident_in    = ident_ff;
      status_in   = status_ff;
      removed_in  = removed_ff;
      idx_in      = idx_ff;
      kept_in     = kept_ff;
      rdp_in      = rdp_ff;
      wrp_in      = wrp_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff;
      ram_wr_data = ident_ff;
      rsp_strobe  = 1'b0;
      unique case (ctl.act)
         ACT_NONE: begin
         end
         ACT_LATCH: begin
            if (accept) begin
               ident_in   = req_ident;
               status_in  = ST_DONE;
               removed_in = '0;
            end
         end
         ACT_PUT: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               ram_wr_en = 1'b1;
               tail_in   = ring_inc(tail_ff);
               count_in  = count_ff + 1'b1;
            end
         end
         ACT_POPCHK: begin
            if (count_ff == '0 || ram_rd_data != ident_ff) begin
               status_in = ST_IGNORED;
            end else begin
               head_in    = ring_inc(head_ff);
               count_in   = count_ff - 1'b1;
               removed_in = CNT_W'(1);
            end
         end
         ACT_DELINIT: begin
            idx_in  = '0;
            kept_in = '0;
            rdp_in  = head_ff;
            wrp_in  = head_ff;
         end
         ACT_DELCHK: begin
            // survivors slide down to the write pointer
            if (ram_rd_data != ident_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wrp_ff;
               ram_wr_data = ram_rd_data;
               wrp_in      = ring_inc(wrp_ff);
               kept_in     = kept_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            rdp_in = ring_inc(rdp_ff);
         end
         ACT_DELEND: begin
            removed_in = count_ff - kept_ff;
            count_in   = kept_ff;
            tail_in    = wrp_ff;
         end
         ACT_EMIT: begin
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign walk_done         = (idx_ff == count_ff);
   assign ram_rd_en         = (ctl.rd != RD_NONE);
   assign ram_rd_addr       = (ctl.rd == RD_WALK) ? rdp_ff : head_ff;
   assign rsp_status        = status_ff;
   assign rsp_occupancy     = count_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_head_valid    = (count_ff != '0);
   assign rsp_head_ident    = rsp_head_valid ? ram_rd_data : '0;

endmodule

FILE: rtl/ring_fifo_with_match_delete.sv
// Circular queue of requester identifiers with put, pop-if-at-head and delete-all-matches,
// run by a small microprogram over a single-port-read slot RAM. An operation is taken when
// start is high and busy is low. Its result shows on the rsp_ ports for exactly one cycle
// with rsp_strobe and must be captured then, since the receiver cannot stall the block.
// After acceptance, put runs a write step, pop a head read and a check, an unused code
// nothing more, and delete an init step, a RAM read and a check per queue entry and an end
// step. Each then does a registered RAM read of the head slot before the strobe. Busy drops
// the cycle after the strobe, so a new operation is taken only once the last one is done.
module ring_fifo_with_match_delete
   import rfmd_pkg::*;
#(
   parameter int DEPTH   = DEPTH_DEF,
   parameter int ID_BITS = ID_BITS_DEF,
   localparam int PTR_W  = $clog2(DEPTH),
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [ID_BITS-1:0] req_ident,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [CNT_W-1:0]   rsp_occupancy,
   output logic [CNT_W-1:0]   rsp_removed_count,
   output logic               rsp_head_valid,
   output logic [ID_BITS-1:0] rsp_head_ident
);

`include "ring_fifo_with_match_delete_assert.svh"

   cond_type           cond;
   ctl_type            ctl;
   logic               accept;
   logic               walk_done;
   logic               ram_wr_en;
   logic [PTR_W-1:0]   ram_wr_addr;
   logic [ID_BITS-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [PTR_W-1:0]   ram_rd_addr;
   logic [ID_BITS-1:0] ram_rd_data;

   assign accept = start && !busy;
   assign cond   = '{accept: accept, func: func_type'(req_func), walk_done: walk_done};

   rfmd_useq u_useq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctl   (ctl),
      .busy  (busy)
   );

   rfmd_dp #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .accept            (accept),
      .req_ident         (req_ident),
      .walk_done         (walk_done),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_removed_count (rsp_removed_count),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_ident    (rsp_head_ident)
   );

   rfmd_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   `RFMD_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `RFMD_ASSERT_NEXT(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `RFMD_ASSERT_NOW(a_occ_range, clock, reset, rsp_strobe, rsp_occupancy <= CNT_W'(DEPTH))
   `RFMD_ASSERT_NOW(a_reject_none, clock, reset, rsp_strobe && rsp_status != ST_DONE,
                    rsp_removed_count == '0)

endmodule

FILE: tb/tb_ring_fifo_with_match_delete.sv
module tb_ring_fifo_with_match_delete;
   import rfmd_pkg::*;

   localparam int SLOTS      = 16;
   localparam int STALL_MAX  = 2000;
   localparam int DRAIN_STEP = 200;

   typedef struct packed {
      func_type   fn;
      logic [7:0] id;
   } op_beat_type;

   typedef struct packed {
      status_type status;
      logic [4:0] occupancy;
      logic [4:0] removed;
      logic       head_valid;
      logic [7:0] head_id;
   } fifo_rsp_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_func = FN_PUT;
   logic [7:0] req_ident = 8'd0;
   logic       rsp_strobe;
   logic [1:0] rsp_status;
   logic [4:0] rsp_occupancy;
   logic [4:0] rsp_removed_count;
   logic       rsp_head_valid;
   logic [7:0] rsp_head_ident;

   op_beat_type  op_backlog[$];
   fifo_rsp_type rsp_expected[$];
   int           ops_total;
   int           accepted_n = 0;
   int           drain_at = 30;
   int           mismatch_n = 0;
   int           stall_n = 0;
   logic         beat_taken = 1'b0;

   // shadow of the queue contents
   logic [7:0] ring [SLOTS];
   logic [3:0] q_head = '0;
   logic [3:0] q_tail = '0;
   logic [4:0] q_count = '0;

   ring_fifo_with_match_delete DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_ident         (req_ident),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_removed_count (rsp_removed_count),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_head_ident    (rsp_head_ident)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic fifo_rsp_type fifo_apply(input func_type fn, input logic [7:0] id);
      fifo_rsp_type r;
      logic [4:0]   kept;
      logic [3:0]   idx;
      logic [7:0]   v;
      r = '0;
      r.status = ST_DONE;
      case (fn)
         FN_PUT: begin
            if (q_count == SLOTS) begin
               r.status = ST_FULL;
            end else begin
               ring[q_tail] = id;
               q_tail = q_tail + 4'd1;
               q_count = q_count + 5'd1;
            end
         end
         FN_POP: begin
            if (q_count == 0 || ring[q_head] != id) begin
               r.status = ST_IGNORED;
            end else begin
               q_head = q_head + 4'd1;
               q_count = q_count - 5'd1;
               r.removed = 5'd1;
            end
         end
         FN_DEL: begin
            kept = '0;
            for (int i = 0; i < q_count; i++) begin
               idx = q_head + i[3:0];
               v = ring[idx];
               if (v != id) begin
                  idx = q_head + kept[3:0];
                  ring[idx] = v;
                  kept = kept + 5'd1;
               end
            end
            r.removed = q_count - kept;
            q_count = kept;
            q_tail = q_head + kept[3:0];
         end
         default: begin
         end
      endcase
      r.occupancy = q_count;
      r.head_valid = (q_count != 0);
      r.head_id = r.head_valid ? ring[q_head] : 8'd0;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d (accepted %0d)",
               what, got, want, accepted_n);
      mismatch_n++;
   endtask

   task automatic queue_op(input func_type fn, input logic [7:0] id);
      op_beat_type b;
      b.fn = fn;
      b.id = id;
      op_backlog.push_back(b);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !beat_taken) begin
      end else if (op_backlog.size() == 0 ||
                   (accepted_n == drain_at && rsp_expected.size() != 0) ||
                   ((accepted_n < 250 || accepted_n >= 400) && $urandom_range(99) < 11)) begin
         start <= 1'b0;
      end else begin
         op_beat_type b;
         b = op_backlog.pop_front();
         start <= 1'b1;
         req_func <= b.fn;
         req_ident <= b.id;
      end
      if (accepted_n == drain_at && rsp_expected.size() == 0) begin
         drain_at <= drain_at + DRAIN_STEP;
      end
   end

   // monitor
   always @(posedge clock) begin
      fifo_rsp_type want;
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (rsp_expected.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_occupancy, -1);
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch("occupancy", rsp_occupancy, want.occupancy);
               if (rsp_removed_count !== want.removed)
                  report_mismatch("removed_count", rsp_removed_count, want.removed);
               if (rsp_head_valid !== want.head_valid)
                  report_mismatch("head_valid", rsp_head_valid, want.head_valid);
               if (rsp_head_ident !== want.head_id)
                  report_mismatch("head_ident", rsp_head_ident, want.head_id);
            end
         end
         beat_taken <= start && !busy;
         if (start && !busy) begin
            rsp_expected.push_back(fifo_apply(func_type'(req_func), req_ident));
            accepted_n <= accepted_n + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe)
            stall_n <= 0;
         else
            stall_n <= stall_n + 1;
         if (stall_n == STALL_MAX) begin
            $display("tb_ring_fifo_with_match_delete NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int         r;
      int         mode;
      logic [7:0] pool [3];
      func_type   fn;

      // fill every slot so no unwritten entry is ever read
      queue_op(FN_PUT, 8'h00);
      queue_op(FN_PUT, 8'hFF);
      queue_op(FN_PUT, 8'h5A);
      queue_op(FN_PUT, 8'hA5);
      queue_op(FN_PUT, 8'h5A);
      queue_op(FN_PUT, 8'h5A);
      queue_op(FN_PUT, 8'hFF);
      queue_op(FN_PUT, 8'h00);
      queue_op(FN_PUT, 8'h5A);
      queue_op(FN_PUT, 8'hA5);
      queue_op(FN_PUT, 8'h5A);
      queue_op(FN_PUT, 8'h5A);
      queue_op(FN_PUT, 8'hFF);
      queue_op(FN_PUT, 8'h5A);
      queue_op(FN_PUT, 8'h5A);
      queue_op(FN_PUT, 8'hA5);
      queue_op(FN_PUT, 8'h33);
      queue_op(FN_POP, 8'h77);
      queue_op(FN_POP, 8'h00);
      queue_op(FN_DEL, 8'h5A);
      queue_op(FN_DEL, 8'h99);
      queue_op(FN_NOP, 8'hC3);
      queue_op(FN_DEL, 8'hFF);
      queue_op(FN_DEL, 8'hA5);
      queue_op(FN_DEL, 8'h00);
      queue_op(FN_DEL, 8'h00);
      queue_op(FN_POP, 8'h00);

      // fill, drain and mixed phases over a small pool of identifiers
      for (int blk = 0; blk < 16; blk++) begin
         mode = $urandom_range(2);
         for (int k = 0; k < 3; k++)
            pool[k] = 8'($urandom_range(255));
         repeat (40) begin
            r = $urandom_range(99);
            if (r >= 97)
               fn = FN_NOP;
            else if (r < (mode == 0 ? 70 : mode == 1 ? 25 : 45))
               fn = FN_PUT;
            else if (r < (mode == 0 ? 85 : mode == 1 ? 70 : 75))
               fn = FN_POP;
            else
               fn = FN_DEL;
            if ($urandom_range(9) == 0)
               queue_op(fn, 8'($urandom_range(255)));
            else
               queue_op(fn, pool[$urandom_range(2)]);
         end
      end
      ops_total = op_backlog.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_n != ops_total) @(posedge clock);
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_n == 0)
         $display("tb_ring_fifo_with_match_delete OK");
      else
         $display("tb_ring_fifo_with_match_delete NOT OK");
      $finish;
   end

endmodule

FILE: ring_fifo_with_match_delete.f
+incdir+rtl
rtl/rfmd_pkg.sv
rtl/rfmd_ram.sv
rtl/rfmd_useq.sv
rtl/rfmd_dp.sv
rtl/ring_fifo_with_match_delete.sv
tb/tb_ring_fifo_with_match_delete.sv
